FILE: src/mf3s_pkg.sv
`timescale 1ns / 1ps

package mf3s_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned PixelBitsDef = 8;

  // Configuration register widths and reset values
  localparam int unsigned FrameWidthW  = 11;
  localparam int unsigned FrameHeightW = 13;
  localparam int unsigned CfgDataW     = 13;
  localparam logic [FrameWidthW-1:0]  FrameWidthRst  = 11'd640;
  localparam logic [FrameHeightW-1:0] FrameHeightRst = 13'd480;

  // Row counter runs up to height + 1 during drain
  localparam int unsigned RowW = FrameHeightW + 1;

  // 3x3 window, row-major: index = row * 3 + column, column 2 is newest
  localparam int unsigned WinSize = 9;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_type_e;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

endpackage

FILE: src/mf3s_median.sv
`timescale 1ns / 1ps

module mf3s_median #(
  parameter int unsigned PIXEL_BITS = mf3s_pkg::PixelBitsDef
) (
  input  logic [mf3s_pkg::WinSize-1:0][PIXEL_BITS-1:0] vals_i,
  input  logic [mf3s_pkg::WinSize-1:0]                 mask_i,
  output logic [PIXEL_BITS-1:0]                        median_o
);
  import mf3s_pkg::*;

  localparam int unsigned CntW = $clog2(WinSize + 1);

  logic [CntW-1:0]               count;
  logic [CntW-1:0]               mid;
  logic [WinSize-1:0][CntW-1:0]  rank;
  logic [WinSize-1:0]            hit;

  always_comb begin
    count = '0;
    for (int i = 0; i < WinSize; i++) begin
      count = count + CntW'(mask_i[i]);
    end
  end

  // upper middle for even counts
  assign mid = count >> 1;

  // Rank of each valid entry among the valid ones; ties broken by position
  // so every rank is unique and exactly one entry hits the middle.
  always_comb begin
    for (int i = 0; i < WinSize; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WinSize; j++) begin
        if (mask_i[j] && ((vals_i[j] < vals_i[i]) ||
                          ((vals_i[j] == vals_i[i]) && (j < i)))) begin
          rank[i] = rank[i] + CntW'(1);
        end
      end
      hit[i] = mask_i[i] && (rank[i] == mid);
    end
  end

  always_comb begin
    median_o = '0;
    for (int i = 0; i < WinSize; i++) begin
      median_o = median_o | ({PIXEL_BITS{hit[i]}} & vals_i[i]);
    end
  end

endmodule

FILE: src/median_filter_3x3_stream.sv
`timescale 1ns / 1ps

// Streaming 3x3 median filter for grey frames in raster order. Pixels and
// drain requests enter on the input channel, one per clock unless stalled; each
// output position gets the median of its in-frame 3x3 neighbors (the fifth
// of nine inside the frame, the upper middle of six or four at borders).
// Pixel number k releases the output for position k - width - 1, so the
// first output follows width + 1 pixels; after the last pixel, drain
// requests release the remaining outputs, one each (a single-row frame
// needs one extra drain). frame_last_o marks the final output, after which
// the next pixel starts a new frame. Pixels beyond the frame and drains
// before its end are taken and dropped. Throughput is one transfer per
// clock while no stall holds the chain; an accepted request passes the
// line-buffer read stage, the window/neighbor stage and the rank-select
// output register in that order, and output stalls hold it in place.
// Each line buffer is one memory with one read and
// one write port per cycle; there is no clearing pass after reset. A
// configuration write restarts the frame and is meant for an idle block.
module median_filter_3x3_stream #(
  parameter int unsigned MAX_WIDTH  = mf3s_pkg::MaxWidthDef,
  parameter int unsigned PIXEL_BITS = mf3s_pkg::PixelBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  mf3s_pkg::cfg_reg_e                  cfg_addr_i,
  input  logic [mf3s_pkg::CfgDataW-1:0]       cfg_wdata_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  mf3s_pkg::req_type_e                 req_type_i,
  input  logic [PIXEL_BITS-1:0]               pixel_in_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [PIXEL_BITS-1:0]               median_out_o,
  output logic                                frame_last_o
);
  import mf3s_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_WIDTH);

  typedef logic [WinSize-1:0][PIXEL_BITS-1:0] win_t;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  logic [FrameWidthW-1:0]  frame_width_q;
  logic [FrameHeightW-1:0] frame_height_q;
  logic [ColW:0]           eff_w;
  logic [FrameHeightW-1:0] eff_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i[FrameWidthW-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i[FrameHeightW-1:0];
        default: ;
      endcase
    end
  end

  // width 0 acts as 1, oversize width clamps to the line buffer depth
  always_comb begin
    if (frame_width_q == '0) begin
      eff_w = (ColW+1)'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      eff_w = (ColW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (ColW+1)'(frame_width_q);
    end
  end

  assign eff_h = (frame_height_q == '0) ? FrameHeightW'(1) : frame_height_q;

  // ---------------------------------------------------------------------
  // Handshake chain: input -> stage A -> stage B -> output register
  // ---------------------------------------------------------------------
  logic a_valid_q, b_valid_q, out_valid_q;
  logic a_emit_q;
  logic out_ready, b_ready, b_go, a_go, a_ready;
  logic in_acc, take;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign b_go       = b_valid_q && out_ready;
  assign b_ready    = !b_valid_q || out_ready;
  assign a_go       = a_valid_q && (!a_emit_q || b_ready);
  assign a_ready    = !a_valid_q || a_go;
  assign in_stall_o = !a_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------
  // Raster position and neighbor masks (front end)
  // ---------------------------------------------------------------------
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] h_ext, h_p1, h_p2;
  logic            is_drain, in_frame, ignore;
  logic            wrap, col_end, emit_d, last_d;
  logic            ge1, ge2, ge3;
  logic [2:0]      rv, cv;
  logic [WinSize-1:0] mask_d;
  logic [PIXEL_BITS-1:0] pix_d;

  assign h_ext = RowW'(eff_h);
  assign h_p1  = h_ext + RowW'(1);
  assign h_p2  = h_ext + RowW'(2);

  assign is_drain = (req_type_i == REQ_DRAIN);
  assign in_frame = row_q < h_ext;
  // pixels past the frame and drains inside it change nothing
  assign ignore   = is_drain ? in_frame : !in_frame;
  assign take     = in_acc && !ignore;
  assign pix_d    = is_drain ? '0 : pixel_in_i;

  // wrap: the pending output is the last column of an older row and is
  // read from the window before this column shifts in
  assign wrap    = (col_q == '0);
  assign col_end = ({1'b0, col_q} == (eff_w - (ColW+1)'(1)));
  assign emit_d  = (row_q >= RowW'(2)) || ((row_q == RowW'(1)) && !wrap);
  assign last_d  = wrap && (row_q == h_p1);

  assign ge1 = (row_q >= RowW'(1));
  assign ge2 = (row_q >= RowW'(2));
  assign ge3 = (row_q >= RowW'(3));

  // window rows are frame rows row-3.. (wrap) or row-2.. (otherwise)
  assign rv[0] = wrap ? (ge3 && (row_q <= h_p2)) : (ge2 && (row_q <= h_p1));
  assign rv[1] = wrap ? (ge2 && (row_q <= h_p1)) : (ge1 && (row_q <= h_ext));
  assign rv[2] = wrap ? (ge1 && (row_q <= h_ext)) : in_frame;
  assign cv[0] = !wrap && (col_q >= ColW'(2));
  assign cv[1] = wrap ? (eff_w != (ColW+1)'(1)) : 1'b1;
  assign cv[2] = 1'b1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mask_d[i*3+j] = rv[i] & cv[j];
      end
    end
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_we_i) begin
      row_d = '0;
      col_d = '0;
    end else if (take) begin
      if (last_d) begin
        row_d = '0;
        col_d = '0;
      end else if (col_end) begin
        col_d = '0;
        row_d = row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // ---------------------------------------------------------------------
  // Line buffers. A holds the newest row per column, B the one before.
  // B is written in the cycle after the read, from A's registered read data;
  // a read of the same column in that cycle (width 1) takes the bypass.
  // ---------------------------------------------------------------------
  logic [PIXEL_BITS-1:0] lb_a_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] lb_b_mem [MAX_WIDTH];

  logic                  wr_pend_q;
  logic [ColW-1:0]       a_col_q;
  logic [PIXEL_BITS-1:0] a_pix_q, a_rda_q, a_rdb_q, a_bypd_q, a_b;
  logic                  a_byp_q, a_wrap_q, a_last_q;
  logic [WinSize-1:0]    a_mask_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      lb_a_mem[col_q] <= pix_d;
      a_rda_q         <= lb_a_mem[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_rdb_q <= lb_b_mem[col_q];
    end
    if (wr_pend_q) begin
      lb_b_mem[a_col_q] <= a_rda_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= take;
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: read data plus position flags
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (take) begin
      a_pix_q  <= pix_d;
      a_col_q  <= col_q;
      a_byp_q  <= wr_pend_q && (a_col_q == col_q);
      a_bypd_q <= a_rda_q;
      a_emit_q <= emit_d;
      a_wrap_q <= wrap;
      a_mask_q <= mask_d;
      a_last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (take) begin
      a_valid_q <= 1'b1;
    end else if (a_go) begin
      a_valid_q <= 1'b0;
    end
  end

  assign a_b = a_byp_q ? a_bypd_q : a_rdb_q;

  // 3x3 window shifts left by one column per request
  win_t win_q, win_shift, cand;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_shift[i*3+0] = win_q[i*3+1];
      win_shift[i*3+1] = win_q[i*3+2];
    end
    win_shift[2] = a_b;
    win_shift[5] = a_rda_q;
    win_shift[8] = a_pix_q;
  end

  assign cand = a_wrap_q ? win_q : win_shift;

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      win_q <= win_shift;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: masked neighbors, then rank select into the output register
  // ---------------------------------------------------------------------
  win_t               b_vals_q;
  logic [WinSize-1:0] b_mask_q;
  logic               b_last_q;
  logic [PIXEL_BITS-1:0] med;

  always_ff @(posedge clk_i) begin
    if (a_go && a_emit_q) begin
      b_vals_q <= cand;
      b_mask_q <= a_mask_q;
      b_last_q <= a_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_go && a_emit_q) begin
      b_valid_q <= 1'b1;
    end else if (b_go) begin
      b_valid_q <= 1'b0;
    end
  end

  mf3s_median #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_median (
    .vals_i  (b_vals_q),
    .mask_i  (b_mask_q),
    .median_o(med)
  );

  logic [PIXEL_BITS-1:0] median_q;
  logic                  last_q;

  always_ff @(posedge clk_i) begin
    if (b_go) begin
      median_q <= med;
      last_q   <= b_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign median_out_o = median_q;
  assign frame_last_o = last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // the final output of a frame restarts the raster position
  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && last_d |=> (row_q == '0) && (col_q == '0))
    else $error("raster position not cleared after last output");

  // every emitted position has at least itself as a neighbor
  a_mask_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_go && a_emit_q |-> (a_mask_q != '0))
    else $error("empty neighbor mask on an emitted position");

  // stage B keeps its neighbors while the output side is full
  a_stage_b_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !out_ready |=> b_valid_q && $stable(b_mask_q) &&
                                $stable(b_vals_q))
    else $error("stage B changed while blocked");

endmodule

FILE: sim/tb_median_filter_3x3_stream.sv
`timescale 1ns / 1ps

module tb_median_filter_3x3_stream;
  import mf3s_pkg::*;

  localparam int unsigned PixW = PixelBitsDef;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    req_type_e       rtype;
    logic [PixW-1:0] pix;
  } pix_req_t;

  typedef struct packed {
    logic [PixW-1:0] median;
    logic            last;
  } median_exp_t;

  // clock, reset and block inputs, all known from time zero
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  cfg_reg_e            cfg_addr_i  = CFG_FRAME_WIDTH;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  req_type_e           req_type_i  = REQ_PIXEL;
  logic [PixW-1:0]     pixel_in_i  = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [PixW-1:0]     median_out_o;
  logic                frame_last_o;

  median_filter_3x3_stream dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .median_out_o(median_out_o),
    .frame_last_o(frame_last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // requests waiting to be driven, medians waiting to come out
  pix_req_t    pending_reqs[$];
  median_exp_t expected_medians[$];

  // filter state as seen by the predictor
  bit [PixW-1:0]        col_newest[MaxWidthDef];
  bit [PixW-1:0]        col_older[MaxWidthDef];
  bit [PixW-1:0]        win_px[WinSize];
  bit [PixW-1:0]        nbr_vals[WinSize];
  int                   nbr_cnt;
  int unsigned          frame_pos;
  logic [FrameWidthW-1:0]  cur_width  = FrameWidthRst;
  logic [FrameHeightW-1:0] cur_height = FrameHeightRst;

  // run control and bookkeeping
  bit          idle_on       = 1'b1;
  bit          long_hold_req = 1'b0;
  int          long_hold_left;
  int          send_gap;
  int          stall_gap;
  int          err_count;
  int          medians_checked;
  int          frames_done;
  int          items_taken;
  int          in_stall_cycles;
  int          cfg_writes;
  pix_req_t    next_req;
  median_exp_t exp_res;

  function automatic void restart_frame();
    int i;
    frame_pos = 0;
    for (i = 0; i < WinSize; i++) win_px[i] = '0;
  endfunction

  // in-frame window entries; row0/col0 are frame coordinates of window row/col 0
  function automatic void collect_nbrs(int row0, int col0, int first_col, int h);
    int r, c;
    nbr_cnt = 0;
    for (r = 0; r < 3; r++) begin
      if (row0 + r >= 0 && row0 + r < h) begin
        for (c = first_col; c < 3; c++) begin
          if (col0 + c >= 0) begin
            nbr_vals[nbr_cnt] = win_px[r * 3 + c];
            nbr_cnt++;
          end
        end
      end
    end
  endfunction

  task automatic predict_median(input req_type_e rtype, input logic [PixW-1:0] pix_in);
    int unsigned w, h, total, k, c1;
    int          r1, i, j;
    bit          drain;
    bit [PixW-1:0] pix, x;
    median_exp_t res;
    begin
      w = (cur_width == 0) ? 1 : cur_width;
      if (w > MaxWidthDef) w = MaxWidthDef;
      h = (cur_height == 0) ? 1 : cur_height;
      total = w * h;
      drain = (rtype == REQ_DRAIN);
      // pixels past the frame end and drains before it are dropped
      if ((drain && frame_pos >= total) || (!drain && frame_pos < total)) begin
        pix = drain ? '0 : pix_in;
        k = frame_pos;
        r1 = k / w;
        c1 = k % w;
        nbr_cnt = 0;
        // on a row wrap the pending position closes an older row, still in the window
        if (k >= w + 1 && c1 == 0) collect_nbrs(r1 - 3, int'(w) - 3, 1, int'(h));
        for (i = 0; i < 3; i++) begin
          win_px[i * 3]     = win_px[i * 3 + 1];
          win_px[i * 3 + 1] = win_px[i * 3 + 2];
        end
        win_px[2] = col_older[c1];
        win_px[5] = col_newest[c1];
        win_px[8] = pix;
        col_older[c1]  = col_newest[c1];
        col_newest[c1] = pix;
        if (k >= w + 1 && c1 != 0) collect_nbrs(r1 - 2, int'(c1) - 2, 0, int'(h));
        frame_pos = k + 1;
        if (k >= w + 1) begin
          for (i = 1; i < nbr_cnt; i++) begin
            x = nbr_vals[i];
            for (j = i; j > 0 && nbr_vals[j - 1] > x; j--) nbr_vals[j] = nbr_vals[j - 1];
            nbr_vals[j] = x;
          end
          res.median = (nbr_cnt > 0) ? nbr_vals[nbr_cnt / 2] : '0;
          res.last   = (k - w - 1 == total - 1);
          expected_medians.push_back(res);
          if (res.last) restart_frame();
        end
      end
    end
  endtask

  // input side: hold while stalled, else next request or an idle gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_type_i <= REQ_PIXEL;
      pixel_in_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_median(req_type_i, pixel_in_i);
        items_taken++;
      end
      if (in_valid_i && in_stall_o) begin
        in_stall_cycles++;
      end else if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (pending_reqs.size() > 0) begin
        next_req = pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= next_req.rtype;
        pixel_in_i <= next_req.pix;
        if (idle_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 8);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_medians.size() == 0) begin
          $display("%0t: output with nothing expected: median %0d last %0b",
                   $time, median_out_o, frame_last_o);
          err_count++;
        end else begin
          exp_res = expected_medians.pop_front();
          if (median_out_o !== exp_res.median) begin
            $display("%0t: median_out mismatch: expected %0d, actual %0d",
                     $time, exp_res.median, median_out_o);
            err_count++;
          end
          if (frame_last_o !== exp_res.last) begin
            $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                     $time, exp_res.last, frame_last_o);
            err_count++;
          end
          medians_checked++;
          if (exp_res.last) frames_done++;
        end
      end
      if (long_hold_req) begin
        long_hold_left = HoldCycles;
        long_hold_req  = 1'b0;
      end
      if (long_hold_left > 0) begin
        out_stall_i <= 1'b1;
        long_hold_left--;
      end else if (stall_gap > 0) begin
        out_stall_i <= 1'b1;
        stall_gap--;
      end else begin
        out_stall_i <= 1'b0;
        if (idle_on && $urandom_range(0, 9) == 0) stall_gap = $urandom_range(1, 8);
      end
    end
  end

  function automatic logic [PixW-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_req(req_type_e t, logic [PixW-1:0] v);
    pix_req_t r;
    r.rtype = t;
    r.pix   = v;
    pending_reqs.push_back(r);
  endfunction

  // full frame plus the drains that release its tail; noisy adds dropped items
  task automatic queue_frame(input int w, input int h, input bit noisy);
    int i;
    begin
      for (i = 0; i < w * h; i++) begin
        push_req(REQ_PIXEL, rand_pixel());
        if (noisy && i < w * h - 1 && $urandom_range(0, 15) == 0)
          push_req(REQ_DRAIN, rand_pixel());
      end
      if (noisy && $urandom_range(0, 3) == 0) push_req(REQ_PIXEL, rand_pixel());
      for (i = 0; i <= w; i++) push_req(REQ_DRAIN, rand_pixel());
      if (noisy && $urandom_range(0, 3) == 0) push_req(REQ_DRAIN, rand_pixel());
    end
  endtask

  // all requests taken, all medians out, then room for dropped items in flight
  task automatic wait_idle();
    int n;
    begin
      @(negedge clk_i);
      while (pending_reqs.size() != 0 || in_valid_i || expected_medians.size() != 0)
        @(negedge clk_i);
      for (n = 0; n < 10; n++) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= idx;
      cfg_wdata_i <= val;
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      if (idx == CFG_FRAME_WIDTH) cur_width = val[FrameWidthW-1:0];
      else cur_height = val;
      restart_frame();
      cfg_writes++;
      @(negedge clk_i);
    end
  endtask

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int w, h, f, n, nframes, npix, rand_items, gen_w, gen_h;
    logic [CfgDataW-1:0] wval;
    restart_frame();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset widths: a few pixels give nothing yet, an early drain is dropped
    push_req(REQ_PIXEL, 8'd0);
    push_req(REQ_PIXEL, 8'd255);
    push_req(REQ_DRAIN, 8'd255);
    push_req(REQ_PIXEL, 8'd1);
    push_req(REQ_PIXEL, 8'd254);
    wait_idle();

    // 3x3 checkerboard of extremes, mid-frame drain and a stray pixel dropped
    write_reg(CFG_FRAME_WIDTH, 13'd3);
    write_reg(CFG_FRAME_HEIGHT, 13'd3);
    push_req(REQ_PIXEL, 8'd0);
    push_req(REQ_PIXEL, 8'd255);
    push_req(REQ_PIXEL, 8'd0);
    push_req(REQ_PIXEL, 8'd255);
    push_req(REQ_DRAIN, 8'd0);
    push_req(REQ_PIXEL, 8'd0);
    push_req(REQ_PIXEL, 8'd255);
    push_req(REQ_PIXEL, 8'd0);
    push_req(REQ_PIXEL, 8'd255);
    push_req(REQ_PIXEL, 8'd128);
    push_req(REQ_PIXEL, 8'd77);
    repeat (4) push_req(REQ_DRAIN, 8'd0);
    wait_idle();

    // one-pixel frame, extra drain after frame end is dropped
    write_reg(CFG_FRAME_WIDTH, 13'd1);
    write_reg(CFG_FRAME_HEIGHT, 13'd1);
    push_req(REQ_PIXEL, 8'd255);
    repeat (3) push_req(REQ_DRAIN, 8'd255);
    wait_idle();

    // zero width and height act as one
    write_reg(CFG_FRAME_WIDTH, 13'd0);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    queue_frame(1, 1, 1'b0);
    wait_idle();

    // single row: first drain releases nothing
    write_reg(CFG_FRAME_WIDTH, 13'd5);
    write_reg(CFG_FRAME_HEIGHT, 13'd1);
    queue_frame(5, 1, 1'b1);
    wait_idle();

    // all-ones width clips to the line buffer size; cut short before any output
    write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
    write_reg(CFG_FRAME_HEIGHT, 13'd2);
    for (n = 0; n < 20; n++) push_req(REQ_PIXEL, rand_pixel());
    wait_idle();

    // long output hold once medians flow, so the pipe backs up into the input
    write_reg(CFG_FRAME_WIDTH, 13'd12);
    write_reg(CFG_FRAME_HEIGHT, 13'd4);
    queue_frame(12, 4, 1'b0);
    while (expected_medians.size() == 0) @(negedge clk_i);
    long_hold_req = 1'b1;
    wait_idle();

    // tallest frame, cut short by the next write
    write_reg(CFG_FRAME_WIDTH, 13'd3);
    write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
    for (n = 0; n < 60; n++) begin
      push_req(REQ_PIXEL, rand_pixel());
      if ($urandom_range(0, 7) == 0) push_req(REQ_DRAIN, rand_pixel());
    end
    wait_idle();

    // stray upper data bits on a width write are dropped
    write_reg(CFG_FRAME_WIDTH, 13'h1803);
    write_reg(CFG_FRAME_HEIGHT, 13'd4);
    queue_frame(3, 4, 1'b1);
    gen_w = 3;
    gen_h = 4;

    rand_items = 0;
    while (rand_items < 300) begin
      if (rand_items >= 225) idle_on = 1'b0;
      wait_idle();
      n = $urandom_range(0, 19);
      if (n < 14) w = $urandom_range(1, 8);
      else if (n < 19) w = $urandom_range(9, 40);
      else w = 0;
      h = ($urandom_range(0, 19) < 18) ? $urandom_range(1, 5) : 0;
      wval = CfgDataW'(w);
      if ($urandom_range(0, 3) == 0)
        wval[CfgDataW-1:FrameWidthW] = (CfgDataW-FrameWidthW)'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: begin
          write_reg(CFG_FRAME_WIDTH, wval);
          gen_w = (w == 0) ? 1 : w;
        end
        1: begin
          write_reg(CFG_FRAME_HEIGHT, CfgDataW'(h));
          gen_h = (h == 0) ? 1 : h;
        end
        default: begin
          write_reg(CFG_FRAME_HEIGHT, CfgDataW'(h));
          write_reg(CFG_FRAME_WIDTH, wval);
          gen_w = (w == 0) ? 1 : w;
          gen_h = (h == 0) ? 1 : h;
        end
      endcase
      // back-to-back frames check the restart at frame end; the last may break off
      nframes = $urandom_range(1, 3);
      for (f = 0; f < nframes; f++) begin
        if (f == nframes - 1 && $urandom_range(0, 4) == 0) begin
          npix = $urandom_range(1, gen_w * gen_h);
          for (n = 0; n < npix; n++) begin
            push_req(REQ_PIXEL, rand_pixel());
            if ($urandom_range(0, 7) == 0) push_req(REQ_DRAIN, rand_pixel());
          end
          rand_items += npix;
        end else begin
          queue_frame(gen_w, gen_h, 1'b1);
          rand_items += gen_w * gen_h + gen_w + 1;
        end
      end
    end

    wait_idle();
    repeat (10) @(negedge clk_i);
    $display("Run covered %0d input transfers and %0d checked medians over %0d full frames,",
             items_taken, medians_checked, frames_done);
    $display("with %0d register writes and %0d cycles of input back-pressure.",
             cfg_writes, in_stall_cycles);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
